// File: hw/rtl/sha_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash values, round functions and shared types.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned BlkWords = 16;
  localparam int unsigned HashWords = 8;
  localparam int unsigned Rounds = 64;
  localparam int unsigned LenPadPos = 56;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_UPDATE,
    ST_PAD,
    ST_EMIT
  } sha_state_e;

  // request from controller to the round core
  typedef struct packed {
    logic start;
    logic init;
  } core_ctl_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    round_k = k[t];
  endfunction

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    logic [31:0] h [8];
    h = '{32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
          32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};
    init_hash = h[i];
  endfunction

endpackage

// File: hw/rtl/sha_round.sv
// ----------------------------------------------------------------------------
// SHA-256 round core
// Working variables a..h, a 16-word rolling message schedule and the hash
// words. One round per cycle; block words are shifted in from the buffer.
// ----------------------------------------------------------------------------
module sha_round import sha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  core_ctl_t   ctl_i,
  input  logic [31:0] blk_word_i,   // block word for rounds 0..15, in order
  input  logic [2:0]  hash_idx_i,
  output logic [31:0] hash_word_o,
  output logic        done_o
);

  logic [31:0] v_q [8];
  logic [31:0] w_q [16];
  logic [31:0] h_q [8];
  logic [6:0]  t_q;
  logic        run_q, upd_q;
  logic [31:0] wt, s0, s1, t1, t2, wn;

  assign wt = (t_q < 7'd16) ? blk_word_i : wn;
  assign s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
  assign s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
  // schedule word for this round from the previous sixteen
  assign wn = s1 + w_q[9] + s0 + w_q[0];
  assign t1 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
            + (v_q[6] ^ (v_q[4] & (v_q[5] ^ v_q[6]))) + round_k(t_q[5:0]) + wt;
  assign t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
            + ((v_q[0] & v_q[1]) | (v_q[2] & (v_q[0] | v_q[1])));

  assign hash_word_o = h_q[hash_idx_i];
  assign done_o = upd_q;

  // window w_q[0] oldest .. w_q[15] newest: words t-16 .. t-1 at round t
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      upd_q <= 1'b0;
      t_q <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= init_hash(3'(i));
    end else begin
      upd_q <= 1'b0;
      if (ctl_i.init) begin
        for (int i = 0; i < 8; i++) h_q[i] <= init_hash(3'(i));
      end
      if (ctl_i.start) begin
        run_q <= 1'b1;
        t_q <= '0;
      end else if (run_q) begin
        t_q <= t_q + 7'd1;
        if (t_q == 7'(Rounds - 1)) begin
          run_q <= 1'b0;
          upd_q <= 1'b1;
        end
      end
      if (upd_q) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end else if (run_q) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
      // keep the last 16 schedule words; push the one used this round
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wt;
    end
  end

endmodule

// File: hw/rtl/sha256_byte_stream_hasher_unit.sv
// ----------------------------------------------------------------------------
// SHA-256 byte-stream hasher
// Byte-wide message in, eight digest words out per message.
// ----------------------------------------------------------------------------
// Each accepted message byte is written into its byte lane of a 16-word
// block memory. When the block fills, input stalls while it is compressed:
// the memory read is primed, the working variables are loaded, the 64 rounds
// run (the first 16 words read from the memory in the cycle before their
// round), the hash words are updated and the next step is picked. At end of
// message the padding is written to the memory one word a cycle (a second
// block when the length does not fit), each padded block is
// compressed the same way, then the eight words are sent as beats, H0 first,
// tlast on the eighth. Input is not taken while a block is being compressed
// or digest beats remain.
module sha256_byte_stream_hasher_unit import sha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] msg_byte, [8] byte_present, rest zero
  input  logic        s_axis_tlast,   // end_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
  output logic        m_axis_tlast    // digest_last
);

  sha_state_e  st_q, st_d;
  logic [31:0] mem [16];
  logic [31:0] rd_q;
  logic [5:0]  nb_q, nb_d;        // bytes in block
  logic [60:0] cnt_q, cnt_d;
  logic [4:0]  idx_q, idx_d;      // load / pad / emit index
  logic        two_q, two_d;      // a second padded block follows
  logic        fin_q, fin_d;      // on the second padded block (zeros plus length)
  logic        eom_q, eom_d;      // end pending after a full-block compress
  logic        pad_done_q, pad_done_d;
  logic        wr_en;
  logic [3:0]  wr_addr;
  logic [3:0]  wr_be, pad_be;     // byte lanes, [0] is the most significant byte
  logic [31:0] wr_data, pad_w;
  logic        rd_en;
  core_ctl_t   ctl;
  logic        done;
  logic [31:0] hw;
  logic        acc, pres;
  logic [63:0] bits;

  sha_round u_round (
    .clk_i(clk_i), .rst_ni(rst_ni), .ctl_i(ctl), .blk_word_i(rd_q),
    .hash_idx_i(idx_q[2:0]), .hash_word_o(hw), .done_o(done));

  assign acc  = s_axis_tvalid & s_axis_tready;
  assign pres = s_axis_tdata[8];
  assign bits = {cnt_q, 3'b000};

  always_ff @(posedge clk_i) begin
    for (int b = 0; b < 4; b++) begin
      if (wr_en && wr_be[b]) mem[wr_addr][31-8*b -: 8] <= wr_data[31-8*b -: 8];
    end
    if (rd_en) rd_q <= mem[idx_q[3:0]];
  end

  // pad word for slot idx_q: bytes < nb kept, byte nb 0x80, rest 0; length in 14-15
  always_comb begin
    logic [5:0] bp;
    pad_w = '0;
    pad_be = '0;
    for (int b = 0; b < 4; b++) begin
      bp = {idx_q[3:0], 2'(b)};
      if (fin_q || bp >= nb_q) begin
        pad_be[b] = 1'b1;
        pad_w[31-8*b -: 8] = (bp == nb_q && !fin_q) ? 8'h80 : 8'h00;
      end
    end
    if (!(two_q && !fin_q)) begin
      if (idx_q[3:0] == 4'd14) begin
        pad_be = 4'hF;
        pad_w = bits[63:32];
      end
      if (idx_q[3:0] == 4'd15) begin
        pad_be = 4'hF;
        pad_w = bits[31:0];
      end
    end
  end

  always_comb begin
    st_d = st_q; nb_d = nb_q; cnt_d = cnt_q; idx_d = idx_q;
    two_d = two_q; fin_d = fin_q; eom_d = eom_q;
    s_axis_tready = 1'b0; m_axis_tvalid = 1'b0;
    wr_en = 1'b0; wr_addr = idx_q[3:0]; wr_data = pad_w; wr_be = pad_be; rd_en = 1'b0;
    ctl = '0;
    case (st_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (acc) begin
          if (pres) begin
            wr_en = 1'b1;
            wr_addr = nb_q[5:2];
            wr_data = {4{s_axis_tdata[7:0]}};
            wr_be = 4'b0001 << nb_q[1:0];
            nb_d = nb_q + 6'd1;
            cnt_d = cnt_q + 61'd1;
          end
          if (pres && nb_q == 6'd63) begin
            st_d = ST_LOAD; idx_d = '0; eom_d = s_axis_tlast; fin_d = 1'b0;
          end else if (s_axis_tlast) begin
            st_d = ST_PAD; idx_d = '0; fin_d = 1'b0;
            two_d = ((pres ? nb_q + 6'd1 : nb_q) >= 6'(LenPadPos));
          end
        end
      end
      ST_PAD: begin
        // mark the pad words; second pass (fin) writes zeros plus length
        wr_en = 1'b1;
        idx_d = idx_q + 5'd1;
        if (idx_q == 5'd15) begin
          st_d = ST_LOAD; idx_d = '0;
        end
      end
      ST_LOAD: begin
        rd_en = 1'b1; idx_d = '0; ctl.start = 1'b0;
        st_d = ST_ROUND;
      end
      ST_ROUND: begin
        // the read leads its round through rd_q; start pulses with the first word in rd_q
        if (idx_q == 5'd0) ctl.start = 1'b1;
        rd_en = 1'b1;
        if (idx_q < 5'd16) idx_d = idx_q + 5'd1;
        if (idx_q == 5'd15) idx_d = 5'd16;
        if (done) st_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        idx_d = '0;
        if (eom_q) begin
          eom_d = 1'b0; nb_d = '0; two_d = 1'b0; fin_d = 1'b0; st_d = ST_PAD;
        end else if (two_q && !fin_q) begin
          fin_d = 1'b1; nb_d = '0; st_d = ST_PAD;
        end else if (two_q || fin_q || nb_q != '0) begin
          st_d = ST_EMIT;
        end else begin
          st_d = ST_IDLE;
        end
        if (!eom_q && !two_q && !fin_q && nb_q == '0) st_d = ST_IDLE;
        if (!eom_q && (fin_q || (!two_q && pad_done_q))) st_d = ST_EMIT;
      end
      ST_EMIT: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) begin
          idx_d = idx_q + 5'd1;
          if (idx_q == 5'd7) begin
            st_d = ST_IDLE; ctl.init = 1'b1; nb_d = '0; cnt_d = '0;
            two_d = 1'b0; fin_d = 1'b0; idx_d = '0;
          end
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // set when a padded block has been written, cleared in the emit state
  always_comb begin
    pad_done_d = pad_done_q;
    if (st_q == ST_PAD && idx_q == 5'd15) pad_done_d = 1'b1;
    if (st_q == ST_EMIT) pad_done_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; nb_q <= '0; cnt_q <= '0; idx_q <= '0;
      two_q <= 1'b0; fin_q <= 1'b0; eom_q <= 1'b0; pad_done_q <= 1'b0;
    end else begin
      st_q <= st_d; nb_q <= nb_d; cnt_q <= cnt_d; idx_q <= idx_d;
      two_q <= two_d; fin_q <= fin_d; eom_q <= eom_d; pad_done_q <= pad_done_d;
    end
  end

  assign m_axis_tdata = {5'd0, idx_q[2:0], hw};
  assign m_axis_tlast = (idx_q[2:0] == 3'd7);

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("in and out active together");
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
    else $error("beat after last digest word");
  a_done_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> st_q == ST_ROUND) else $error("core finished outside rounds");

endmodule
